// File: hw/rtl/vrrq_pkg.sv
package vrrq_pkg;

   localparam int CAP_BYTES_DEF     = 4096;
   localparam int MAX_MSG_BYTES_DEF = 512;
   localparam int MAX_READ_DEF      = 16;

   localparam int HDR_BYTES = 8;
   localparam logic [31:0] PAD_TYPE = 32'hFFFF_FFFF;

   localparam logic [2:0] KIND_CLAIM   = 3'd0;
   localparam logic [2:0] KIND_STORE   = 3'd1;
   localparam logic [2:0] KIND_COMMIT  = 3'd2;
   localparam logic [2:0] KIND_ABORT   = 3'd3;
   localparam logic [2:0] KIND_READ    = 3'd4;
   localparam logic [2:0] KIND_UNBLOCK = 3'd5;
   localparam logic [2:0] KIND_LOAD    = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ERROR = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LATCH,
      CMD_DISPATCH,
      CMD_CLAIM_PAD,
      CMD_CLAIM_HDR,
      CMD_LOAD_OUT,
      CMD_PUB_WR,
      CMD_UB_HEAD,
      CMD_UB_SCAN,
      CMD_RD_CHK,
      CMD_RD_END,
      CMD_RD_ZERO
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       clr_last;
      logic       claim_go;
      logic       claim_pad;
      logic       ld_ok;
      logic       pub_ok;
      logic       ub_empty;
      logic       hdr_neg;
      logic       hdr_zero;
      logic       scan_go;
      logic       rd_go;
      logic       rd_stop;
      logic       zero_any;
      logic       zero_last;
   } sts_type;

endpackage

// File: hw/rtl/vrrq_ctrl.sv
module vrrq_ctrl import vrrq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_CLAIM_PAD, S_CLAIM_HDR, S_LOAD_OUT,
      S_PUB_WR, S_UB_HEAD, S_UB_SCAN, S_RD_CHK, S_RD_END, S_RD_ZERO
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLEAR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd      = CMD_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd      = CMD_DISPATCH;
            state_in = S_IDLE;
            case (sts.kind)
               KIND_CLAIM:
                  if (sts.claim_go) state_in = sts.claim_pad ? S_CLAIM_PAD : S_CLAIM_HDR;
               KIND_COMMIT, KIND_ABORT:
                  if (sts.pub_ok) state_in = S_PUB_WR;
               KIND_READ:
                  state_in = sts.rd_go ? S_RD_CHK : S_RD_END;
               KIND_UNBLOCK:
                  if (!sts.ub_empty) state_in = S_UB_HEAD;
               KIND_LOAD:
                  if (sts.ld_ok) state_in = S_LOAD_OUT;
               default: state_in = S_IDLE;
            endcase
         end
         S_CLAIM_PAD: begin
            cmd      = CMD_CLAIM_PAD;
            state_in = S_CLAIM_HDR;
         end
         S_CLAIM_HDR: begin
            cmd      = CMD_CLAIM_HDR;
            state_in = S_IDLE;
         end
         S_LOAD_OUT: begin
            cmd      = CMD_LOAD_OUT;
            state_in = S_IDLE;
         end
         S_PUB_WR: begin
            cmd      = CMD_PUB_WR;
            state_in = S_IDLE;
         end
         S_UB_HEAD: begin
            cmd      = CMD_UB_HEAD;
            state_in = (!sts.hdr_neg && sts.hdr_zero && sts.scan_go) ? S_UB_SCAN : S_IDLE;
         end
         S_UB_SCAN: begin
            cmd      = CMD_UB_SCAN;
            state_in = (sts.hdr_zero && sts.scan_go) ? S_UB_SCAN : S_IDLE;
         end
         S_RD_CHK: begin
            cmd      = CMD_RD_CHK;
            state_in = sts.rd_go ? S_RD_CHK : S_RD_END;
         end
         S_RD_END: begin
            cmd      = CMD_RD_END;
            state_in = sts.zero_any ? S_RD_ZERO : S_IDLE;
         end
         S_RD_ZERO: begin
            cmd = CMD_RD_ZERO;
            if (sts.zero_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: hw/rtl/vrrq_dp.sv
module vrrq_dp import vrrq_pkg::*; #(
   parameter int CAP_BYTES     = CAP_BYTES_DEF,
   parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF,
   parameter int MAX_READ      = MAX_READ_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_msg_type,
   input  logic [11:0]        req_msg_length,
   input  logic [11:0]        req_byte_offset,
   input  logic [63:0]        req_store_word,
   input  logic [4:0]         req_count_limit,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_msg_offset,
   output logic signed [31:0] rsp_out_type,
   output logic [9:0]         rsp_out_length,
   output logic [63:0]        rsp_load_word,
   output logic [4:0]         rsp_read_count,
   output logic               rsp_last
);

   localparam int SLOTS = CAP_BYTES / 8;
   localparam int SW    = $clog2(SLOTS);
   localparam int LB    = $clog2(CAP_BYTES);
   localparam int PW    = LB + 1;
   localparam int NB    = $clog2(MAX_READ + 1);
   localparam int LW    = (NB > 5) ? NB : 5;
   localparam logic [PW-1:0] CAPP = PW'(CAP_BYTES);
   localparam logic [PW-1:0] HDRP = PW'(HDR_BYTES);

   logic [63:0] mem [SLOTS];
   logic [63:0] rdata_ff;
   logic [SW-1:0] rd_slot, wr_slot, clr_ff;
   logic [63:0] wr_data;
   logic wr_en;

   logic [2:0]  kind_ff;
   logic [31:0] type_ff;
   logic [11:0] len_ff, off_ff;
   logic [63:0] word_ff;
   logic [LW-1:0] lim_ff, n_ff, n_new;
   logic [63:0] head_ff, tail_ff;
   logic [PW-1:0] scan_ff, bytes_ff, z_ff;
   logic        pend_v_ff;
   logic [11:0] pend_off_ff;
   logic [31:0] pend_type_ff;
   logic [9:0]  pend_len_ff;
   logic [4:0]  pend_cnt_ff;

   // result registers
   logic        emit;
   logic [1:0]  e_status;
   logic [11:0] e_off;
   logic [31:0] e_type;
   logic [9:0]  e_len;
   logic [63:0] e_word;
   logic [4:0]  e_cnt;
   logic        e_last;
   logic        v_ff, last_ff;
   logic [1:0]  st_ff;
   logic [11:0] off_out_ff;
   logic [31:0] type_out_ff;
   logic [9:0]  len_out_ff;
   logic [63:0] word_out_ff;
   logic [4:0]  cnt_out_ff;

   // positions inside the ring
   logic [PW-1:0] hd, ti, pi, to_end, hdr_pos, limit, scan_nxt, contig, rem;
   logic [PW-1:0] stepc, bytes_new, idx, rd_pos, zpos;
   logic [63:0] rec64, req64, used, cap64;
   logic [31:0] off32, offm8, cl_off32, l, t, idx_off32, lm8;
   logic [32:0] step33;
   logic bad, full1, wrap, full2, claim_go, ld_ok, pub_ok, stop, msg;

   always_comb begin
      hd     = {1'b0, head_ff[LB-1:0]};
      ti     = {1'b0, tail_ff[LB-1:0]};
      pi     = {1'b0, tail_ff[LB-1:0]};
      cap64  = 64'(CAP_BYTES);
      rec64  = 64'(len_ff) + 64'(HDR_BYTES);
      req64  = (rec64 + 64'd7) & ~64'd7;
      used   = tail_ff - head_ff;
      full1  = (used > cap64) || (req64 > cap64 - used);
      to_end = CAPP - ti;
      wrap   = req64 > 64'(to_end);
      full2  = wrap && (req64 > 64'(hd));
      bad    = (type_ff == 32'd0) || type_ff[31] || (32'(len_ff) > 32'(MAX_MSG_BYTES));
      claim_go = !bad && !full1 && !full2;
      hdr_pos  = wrap ? '0 : ti;
      cl_off32 = 32'(hdr_pos) + 32'(HDR_BYTES);

      off32  = 32'(off_ff);
      offm8  = off32 - 32'(HDR_BYTES);
      ld_ok  = off32 < 32'(CAP_BYTES);
      pub_ok = (off32 >= 32'(HDR_BYTES)) && (off32[2:0] == 3'd0) &&
               (offm8 <= 32'(CAP_BYTES) - 32'(HDR_BYTES));

      l = rdata_ff[31:0];
      t = rdata_ff[63:32];
      lm8 = l - 32'(HDR_BYTES);

      limit    = (pi > hd) ? pi : CAPP;
      scan_nxt = (cmd == CMD_UB_HEAD) ? hd + HDRP : scan_ff + HDRP;

      contig    = CAPP - hd;
      rem       = contig - bytes_ff;
      step33    = ({1'b0, l} + 33'd7) & ~33'd7;
      stepc     = (step33 > 33'(rem)) ? rem : step33[PW-1:0];
      bytes_new = bytes_ff + stepc;
      idx       = hd + bytes_ff;
      idx_off32 = 32'(idx) + 32'(HDR_BYTES);
      stop      = (l == 32'd0) || l[31];
      msg       = (t != PAD_TYPE);
      n_new     = n_ff + LW'(msg);
      rd_pos    = (cmd == CMD_RD_CHK) ? hd + bytes_new : hd;
      // head has already advanced past the consumed bytes while zeroing
      zpos      = hd - bytes_ff + z_ff;
   end

   always_comb begin
      sts.kind      = kind_ff;
      sts.clr_last  = (clr_ff == SW'(SLOTS - 1));
      sts.claim_go  = claim_go;
      sts.claim_pad = wrap;
      sts.ld_ok     = ld_ok;
      sts.pub_ok    = pub_ok;
      sts.ub_empty  = (head_ff == tail_ff);
      sts.hdr_neg   = l[31];
      sts.hdr_zero  = (l == 32'd0);
      sts.scan_go   = scan_nxt < limit;
      sts.rd_go     = (cmd == CMD_RD_CHK) ?
                      (!stop && (bytes_new < contig) && (n_new < lim_ff)) : (lim_ff != '0);
      sts.rd_stop   = stop;
      sts.zero_any  = (bytes_ff != '0);
      sts.zero_last = (z_ff + HDRP) >= bytes_ff;
   end

   // memory address and write selection
   always_comb begin
      rd_slot = hd[SW+2:3];
      wr_en   = 1'b0;
      wr_slot = hd[SW+2:3];
      wr_data = '0;
      case (cmd)
         CMD_CLEAR: begin
            wr_en   = 1'b1;
            wr_slot = clr_ff;
         end
         CMD_DISPATCH: begin
            case (kind_ff)
               KIND_LOAD:  rd_slot = off32[SW+2:3];
               KIND_COMMIT, KIND_ABORT: rd_slot = offm8[SW+2:3];
               KIND_STORE: begin
                  wr_en   = ld_ok;
                  wr_slot = off32[SW+2:3];
                  wr_data = word_ff;
               end
               default: rd_slot = hd[SW+2:3];
            endcase
         end
         CMD_CLAIM_PAD: begin
            wr_en   = 1'b1;
            wr_slot = ti[SW+2:3];
            wr_data = {PAD_TYPE, 32'(to_end)};
         end
         CMD_CLAIM_HDR: begin
            wr_en   = 1'b1;
            wr_slot = hdr_pos[SW+2:3];
            wr_data = {type_ff, 32'd0 - 32'(rec64)};
         end
         CMD_PUB_WR: begin
            wr_en   = l[31];
            wr_slot = offm8[SW+2:3];
            wr_data = {(kind_ff == KIND_ABORT) ? PAD_TYPE : t, 32'd0 - l};
         end
         CMD_UB_HEAD: begin
            rd_slot = scan_nxt[SW+2:3];
            wr_en   = l[31];
            wr_data = {PAD_TYPE, 32'd0 - l};
         end
         CMD_UB_SCAN: begin
            rd_slot = scan_nxt[SW+2:3];
            wr_en   = (l != 32'd0);
            wr_data = {PAD_TYPE, 32'(scan_ff - hd)};
         end
         CMD_RD_CHK: rd_slot = rd_pos[SW+2:3];
         CMD_RD_ZERO: begin
            wr_en   = 1'b1;
            wr_slot = zpos[SW+2:3];
         end
         default: rd_slot = hd[SW+2:3];
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_slot] <= wr_data;
      rdata_ff <= mem[rd_slot];
   end

   // result selection
   always_comb begin
      emit     = 1'b0;
      e_status = ST_OK;
      e_off    = '0;
      e_type   = '0;
      e_len    = '0;
      e_word   = '0;
      e_cnt    = '0;
      e_last   = 1'b1;
      case (cmd)
         CMD_DISPATCH: begin
            case (kind_ff)
               KIND_CLAIM: begin
                  emit     = !claim_go;
                  e_status = bad ? ST_ERROR : ST_FULL;
               end
               KIND_STORE: begin
                  emit     = 1'b1;
                  e_status = ld_ok ? ST_OK : ST_ERROR;
               end
               KIND_LOAD: begin
                  emit     = !ld_ok;
                  e_status = ST_ERROR;
               end
               KIND_COMMIT, KIND_ABORT: begin
                  emit     = !pub_ok;
                  e_status = ST_ERROR;
               end
               KIND_UNBLOCK: begin
                  emit     = (head_ff == tail_ff);
                  e_status = ST_EMPTY;
               end
               KIND_READ: emit = 1'b0;
               default: begin
                  emit     = 1'b1;
                  e_status = ST_ERROR;
               end
            endcase
         end
         CMD_CLAIM_HDR: begin
            emit  = 1'b1;
            e_off = cl_off32[11:0];
         end
         CMD_LOAD_OUT: begin
            emit   = 1'b1;
            e_word = rdata_ff;
         end
         CMD_PUB_WR: begin
            emit     = 1'b1;
            e_status = l[31] ? ST_OK : ST_ERROR;
         end
         CMD_UB_HEAD: begin
            emit     = l[31] || (l != 32'd0) || !sts.scan_go;
            e_status = l[31] ? ST_OK : ST_EMPTY;
         end
         CMD_UB_SCAN: begin
            emit     = (l != 32'd0) || !sts.scan_go;
            e_status = (l != 32'd0) ? ST_OK : ST_EMPTY;
         end
         CMD_RD_CHK: begin
            // hand out the held message once a newer one shows up
            emit   = !stop && msg && pend_v_ff;
            e_off  = pend_off_ff;
            e_type = pend_type_ff;
            e_len  = pend_len_ff;
            e_cnt  = pend_cnt_ff;
            e_last = 1'b0;
         end
         CMD_RD_END: begin
            emit     = 1'b1;
            e_status = pend_v_ff ? ST_OK : ST_EMPTY;
            e_off    = pend_v_ff ? pend_off_ff : '0;
            e_type   = pend_v_ff ? pend_type_ff : '0;
            e_len    = pend_v_ff ? pend_len_ff : '0;
            e_cnt    = pend_v_ff ? pend_cnt_ff : '0;
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= 1'b0;
         clr_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         v_ff <= emit;
         if (cmd == CMD_CLEAR) clr_ff <= clr_ff + SW'(1);
         if (cmd == CMD_CLAIM_HDR)
            tail_ff <= tail_ff + req64 + (wrap ? 64'(to_end) : 64'd0);
         if (cmd == CMD_RD_END) head_ff <= head_ff + 64'(bytes_ff);
         if (cmd == CMD_DISPATCH) pend_v_ff <= 1'b0;
         else if (cmd == CMD_RD_CHK && !stop && msg) pend_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         st_ff       <= e_status;
         off_out_ff  <= e_off;
         type_out_ff <= e_type;
         len_out_ff  <= e_len;
         word_out_ff <= e_word;
         cnt_out_ff  <= e_cnt;
         last_ff     <= e_last;
      end
      if (cmd == CMD_LATCH) begin
         kind_ff <= req_kind;
         type_ff <= req_msg_type;
         len_ff  <= req_msg_length;
         off_ff  <= req_byte_offset;
         word_ff <= req_store_word;
         lim_ff  <= (32'(req_count_limit) > 32'(MAX_READ)) ? LW'(MAX_READ)
                                                           : LW'(req_count_limit);
      end
      if (cmd == CMD_DISPATCH) begin
         bytes_ff <= '0;
         n_ff     <= '0;
      end
      if (cmd == CMD_UB_HEAD || cmd == CMD_UB_SCAN) scan_ff <= scan_nxt;
      if (cmd == CMD_RD_CHK && !stop) begin
         bytes_ff <= bytes_new;
         if (msg) begin
            n_ff         <= n_new;
            pend_off_ff  <= idx_off32[11:0];
            pend_type_ff <= t;
            pend_len_ff  <= lm8[9:0];
            pend_cnt_ff  <= n_new[4:0];
         end
      end
      if (cmd == CMD_RD_END) z_ff <= '0;
      else if (cmd == CMD_RD_ZERO) z_ff <= z_ff + HDRP;
   end

   assign rsp_valid      = v_ff;
   assign rsp_status     = v_ff ? st_ff : '0;
   assign rsp_msg_offset = v_ff ? off_out_ff : '0;
   assign rsp_out_type   = v_ff ? type_out_ff : '0;
   assign rsp_out_length = v_ff ? len_out_ff : '0;
   assign rsp_load_word  = v_ff ? word_out_ff : '0;
   assign rsp_read_count = v_ff ? cnt_out_ff : '0;
   assign rsp_last       = v_ff ? last_ff : 1'b0;

endmodule

// File: hw/rtl/variable_record_ring_queue.sv
// Ring queue of variable-length records in a store of CAP_BYTES/8 64-bit slots. A request
// is taken when start is high and busy is low; each result appears for one cycle with
// rsp_valid and cannot be held off, and rsp_last marks the final result of a request. After
// reset the block sweeps the store to zero, one slot per cycle, with busy high. A claim
// with wrap writes a padding header before the record header. Unblock on a non-empty queue
// may scan slot by slot; read examines headers one by one, then zeroes the consumed slots.
module variable_record_ring_queue import vrrq_pkg::*; #(
   parameter int CAP_BYTES     = CAP_BYTES_DEF,
   parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF,
   parameter int MAX_READ      = MAX_READ_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_msg_type,
   input  logic [11:0]        req_msg_length,
   input  logic [11:0]        req_byte_offset,
   input  logic [63:0]        req_store_word,
   input  logic [4:0]         req_count_limit,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_msg_offset,
   output logic signed [31:0] rsp_out_type,
   output logic [9:0]         rsp_out_length,
   output logic [63:0]        rsp_load_word,
   output logic [4:0]         rsp_read_count,
   output logic               rsp_last
);

   cmd_type cmd;
   sts_type sts;

   vrrq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   vrrq_dp #(
      .CAP_BYTES     (CAP_BYTES),
      .MAX_MSG_BYTES (MAX_MSG_BYTES),
      .MAX_READ      (MAX_READ)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_msg_type    (req_msg_type),
      .req_msg_length  (req_msg_length),
      .req_byte_offset (req_byte_offset),
      .req_store_word  (req_store_word),
      .req_count_limit (req_count_limit),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_msg_offset  (rsp_msg_offset),
      .rsp_out_type    (rsp_out_type),
      .rsp_out_length  (rsp_out_length),
      .rsp_load_word   (rsp_load_word),
      .rsp_read_count  (rsp_read_count),
      .rsp_last        (rsp_last)
   );

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request taken but block not busy");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> busy) else $error("non-final result with block idle");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_last)
      else $error("empty status on a non-final result");

   a_count_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_count != 5'd0) |-> (rsp_status == ST_OK))
      else $error("message count on a failed result");
`endif

endmodule

// File: tb/tb_variable_record_ring_queue.sv
`timescale 1ns / 1ps

module tb_variable_record_ring_queue;
   import vrrq_pkg::*;

   localparam int SLOTS      = CAP_BYTES_DEF / 8;
   localparam int CYCLE_CAP  = 1000000;
   localparam int DRAIN_WAIT = 700;
   localparam int N_RANDOM   = 390;

   typedef struct {
      logic [1:0]         status;
      logic [11:0]        off;
      logic signed [31:0] typ;
      logic [9:0]         len;
      logic [63:0]        word;
      logic [4:0]         cnt;
      logic               last;
   } rsp_t;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] typ;
      logic [11:0] len;
      logic [11:0] off;
      logic [63:0] word;
      logic [4:0]  lim;
      logic        pinned;
      logic [1:0]  pin_status;
   } req_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_kind = '0;
   logic signed [31:0] req_msg_type = '0;
   logic [11:0]        req_msg_length = '0;
   logic [11:0]        req_byte_offset = '0;
   logic [63:0]        req_store_word = '0;
   logic [4:0]         req_count_limit = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [11:0]        rsp_msg_offset;
   logic signed [31:0] rsp_out_type;
   logic [9:0]         rsp_out_length;
   logic [63:0]        rsp_load_word;
   logic [4:0]         rsp_read_count;
   logic               rsp_last;

   logic               pin_valid = 1'b0;
   logic [1:0]         pin_status = '0;

   // mirror of the record ring
   logic [63:0] slot_mem [SLOTS];
   logic [63:0] head_pos;
   logic [63:0] tail_pos;
   rsp_t        expected_q[$];
   logic [11:0] open_offsets[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          idle_pct = 0;

   variable_record_ring_queue u_top (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic rsp_t plain(input logic [1:0] st);
      rsp_t r;
      r = '{status: st, off: '0, typ: '0, len: '0, word: '0, cnt: '0, last: 1'b1};
      return r;
   endfunction

   function automatic void put_hdr(input logic [63:0] idx, input logic [31:0] len,
                                   input logic [31:0] typ);
      slot_mem[(idx >> 3) % SLOTS] = {typ, len};
   endfunction

   function automatic logic [31:0] len_of(input logic [63:0] idx);
      return slot_mem[(idx >> 3) % SLOTS][31:0];
   endfunction

   function automatic rsp_t ring_claim(input logic [31:0] typ, input logic [11:0] len);
      logic [63:0] rec, need, used, ti, to_end, pad;
      rsp_t r;
      r = plain(ST_ERROR);
      if (typ == 0 || typ[31] || len > MAX_MSG_BYTES_DEF) return r;
      r.status = ST_FULL;
      rec = 64'(len) + HDR_BYTES;
      need = (rec + 7) & ~64'd7;
      used = tail_pos - head_pos;
      if (used > CAP_BYTES_DEF || need > CAP_BYTES_DEF - used) return r;
      ti = tail_pos % CAP_BYTES_DEF;
      to_end = CAP_BYTES_DEF - ti;
      pad = 0;
      if (need > to_end) begin
         if (need > head_pos % CAP_BYTES_DEF) return r;
         pad = to_end;
      end
      tail_pos += need + pad;
      if (pad != 0) begin
         put_hdr(ti, pad[31:0], PAD_TYPE);
         ti = 0;
      end
      put_hdr(ti, 32'd0 - rec[31:0], typ);
      r.status = ST_OK;
      r.off = 12'(ti + HDR_BYTES);
      open_offsets.push_back(r.off);
      return r;
   endfunction

   function automatic logic [1:0] ring_publish(input logic [11:0] off, input logic as_pad);
      logic [31:0] l;
      logic [63:0] hdr;
      if (off < HDR_BYTES || off[2:0] != 0) return ST_ERROR;
      hdr = 64'(off) - HDR_BYTES;
      l = len_of(hdr);
      if (!l[31]) return ST_ERROR;
      put_hdr(hdr, 32'd0 - l, as_pad ? PAD_TYPE : slot_mem[(hdr >> 3) % SLOTS][63:32]);
      return ST_OK;
   endfunction

   function automatic logic [1:0] ring_unblock();
      logic [63:0] ci, pi, lim;
      logic [31:0] l;
      if (head_pos == tail_pos) return ST_EMPTY;
      ci = head_pos % CAP_BYTES_DEF;
      pi = tail_pos % CAP_BYTES_DEF;
      l = len_of(ci);
      if (l[31]) begin
         put_hdr(ci, 32'd0 - l, PAD_TYPE);
         return ST_OK;
      end
      if (l != 0) return ST_EMPTY;
      lim = pi > ci ? pi : CAP_BYTES_DEF;
      for (logic [63:0] i = ci + 8; i < lim; i += 8) begin
         if (len_of(i) != 0) begin
            put_hdr(ci, 32'(i - ci), PAD_TYPE);
            return ST_OK;
         end
      end
      return ST_EMPTY;
   endfunction

   function automatic void ring_read(input logic [4:0] lim_in);
      logic [63:0] hi, contig, bytes, idx, stride, lim;
      logic [31:0] l, t;
      int n;
      rsp_t r;
      hi = head_pos % CAP_BYTES_DEF;
      contig = CAP_BYTES_DEF - hi;
      bytes = 0;
      n = 0;
      lim = lim_in > MAX_READ_DEF ? MAX_READ_DEF : lim_in;
      while (bytes < contig && n < lim) begin
         idx = hi + bytes;
         l = len_of(idx);
         if (l == 0 || l[31]) break;
         stride = (64'(l) + 7) & ~64'd7;
         if (stride > contig - bytes) stride = contig - bytes;
         bytes += stride;
         t = slot_mem[(idx >> 3) % SLOTS][63:32];
         if (t == PAD_TYPE) continue;
         n++;
         r = plain(ST_OK);
         r.off = 12'(idx + HDR_BYTES);
         r.typ = t;
         r.len = 10'(l - HDR_BYTES);
         r.cnt = 5'(n);
         r.last = 1'b0;
         expected_q.push_back(r);
      end
      for (logic [63:0] s = 0; s < bytes; s += 8) slot_mem[((hi + s) >> 3) % SLOTS] = '0;
      head_pos += bytes;
      if (n == 0) expected_q.push_back(plain(ST_EMPTY));
      else expected_q[$].last = 1'b1;
   endfunction

   // work out the results of one accepted request
   function automatic void predict_request(input logic [2:0] kind, input logic [31:0] typ,
                                           input logic [11:0] len, input logic [11:0] off,
                                           input logic [63:0] word, input logic [4:0] lim);
      rsp_t r;
      r = plain(ST_OK);
      case (kind)
         KIND_CLAIM:   r = ring_claim(typ, len);
         KIND_STORE:   slot_mem[off >> 3] = word;
         KIND_COMMIT:  r.status = ring_publish(off, 1'b0);
         KIND_ABORT:   r.status = ring_publish(off, 1'b1);
         KIND_READ:    ring_read(lim);
         KIND_UNBLOCK: r.status = ring_unblock();
         KIND_LOAD:    r.word = slot_mem[off >> 3];
         default:      r.status = ST_ERROR;
      endcase
      if (kind != KIND_READ) expected_q.push_back(r);
   endfunction

   always @(posedge clock) begin
      rsp_t e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report("result with nothing expected", 64'(rsp_status), 0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_status !== e.status) report("status", 64'(rsp_status), 64'(e.status));
            if (rsp_msg_offset !== e.off) report("msg_offset", 64'(rsp_msg_offset), 64'(e.off));
            if (rsp_out_type !== e.typ) report("out_type", 64'(rsp_out_type), 64'(e.typ));
            if (rsp_out_length !== e.len) report("out_length", 64'(rsp_out_length), 64'(e.len));
            if (rsp_load_word !== e.word) report("load_word", rsp_load_word, e.word);
            if (rsp_read_count !== e.cnt) report("read_count", 64'(rsp_read_count), 64'(e.cnt));
            if (rsp_last !== e.last) report("last", 64'(rsp_last), 64'(e.last));
         end
      end
      if (!reset && start && !busy) begin
         predict_request(req_kind, req_msg_type, req_msg_length, req_byte_offset,
                         req_store_word, req_count_limit);
         // a typed expectation overrides the predicted status of this request
         if (pin_valid) expected_q[$].status = pin_status;
      end
   end

   task automatic issue(input req_t q);
      int gap;
      start <= 1'b1;
      req_kind <= q.kind;
      req_msg_type <= q.typ;
      req_msg_length <= q.len;
      req_byte_offset <= q.off;
      req_store_word <= q.word;
      req_count_limit <= q.lim;
      pin_valid <= q.pinned;
      pin_status <= q.pin_status;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_t row(input logic [2:0] kind, input logic [31:0] typ,
                                input logic [11:0] len, input logic [11:0] off,
                                input logic [63:0] word, input logic [4:0] lim,
                                input logic pinned, input logic [1:0] st);
      req_t q;
      q = '{kind, typ, len, off, word, lim, pinned, st};
      return q;
   endfunction

   function automatic req_t random_request();
      req_t q;
      int pick;
      q = row($urandom_range(7), $urandom, $urandom_range(4095), $urandom_range(4095),
              {$urandom, $urandom}, $urandom_range(31), 1'b0, ST_OK);
      pick = $urandom_range(99);
      if (pick < 30) begin
         q.kind = KIND_CLAIM;
         if ($urandom_range(9) < 8) q.typ = $urandom_range(1, 1000);
         case ($urandom_range(9))
            0:       q.len = $urandom_range(4095);
            1, 2:    q.len = $urandom_range(512);
            default: q.len = $urandom_range(64);
         endcase
      end else if (pick < 45) begin
         q.kind = KIND_STORE;
         if (open_offsets.size() != 0 && $urandom_range(9) < 8)
            q.off = open_offsets[$urandom_range(open_offsets.size() - 1)];
      end else if (pick < 65) begin
         q.kind = $urandom_range(3) == 0 ? KIND_ABORT : KIND_COMMIT;
         if (open_offsets.size() != 0 && $urandom_range(9) < 9) begin
            pick = $urandom_range(open_offsets.size() - 1);
            q.off = open_offsets[pick];
            open_offsets.delete(pick);
         end
      end else if (pick < 82) begin
         q.kind = KIND_READ;
         if ($urandom_range(3) != 0) q.lim = $urandom_range(1, 16);
      end else if (pick < 87) begin
         q.kind = KIND_UNBLOCK;
      end else if (pick < 94) begin
         q.kind = KIND_LOAD;
      end
      return q;
   endfunction

   req_t directed[] = '{
      row(KIND_READ,    0,            0,    0,  0,      4,  1, ST_EMPTY),
      row(KIND_UNBLOCK, 0,            0,    0,  0,      0,  1, ST_EMPTY),
      row(KIND_CLAIM,   0,            8,    0,  0,      0,  1, ST_ERROR),
      row(KIND_CLAIM,   32'h80000000, 8,    0,  0,      0,  1, ST_ERROR),
      row(KIND_CLAIM,   5,            513,  0,  0,      0,  1, ST_ERROR),
      row(KIND_CLAIM,   5,            4095, 0,  0,      0,  1, ST_ERROR),
      row(KIND_CLAIM,   1,            0,    0,  0,      0,  0, ST_OK),
      row(KIND_CLAIM,   32'h7FFFFFFF, 512,  0,  0,      0,  0, ST_OK),
      row(KIND_STORE,   0,            0,    16, '1,     0,  1, ST_OK),
      row(KIND_STORE,   0,            0,    4095, 64'h8000_0000_0000_0001, 0, 1, ST_OK),
      row(KIND_LOAD,    0,            0,    16, 0,      0,  0, ST_OK),
      row(KIND_LOAD,    0,            0,    4095, 0,    0,  0, ST_OK),
      row(KIND_COMMIT,  0,            0,    16, 0,      0,  1, ST_OK),
      row(KIND_COMMIT,  0,            0,    16, 0,      0,  1, ST_ERROR),
      row(KIND_COMMIT,  0,            0,    0,  0,      0,  1, ST_ERROR),
      row(KIND_ABORT,   0,            0,    12, 0,      0,  1, ST_ERROR),
      row(KIND_READ,    0,            0,    0,  0,      16, 0, ST_OK),
      row(KIND_ABORT,   0,            0,    8,  0,      0,  1, ST_OK),
      row(KIND_READ,    0,            0,    0,  0,      0,  1, ST_EMPTY),
      row(KIND_READ,    0,            0,    0,  0,      31, 0, ST_OK),
      row(3'd7,         0,            0,    0,  0,      0,  1, ST_ERROR),
      row(KIND_CLAIM,   3,            100,  0,  0,      0,  0, ST_OK),
      row(KIND_UNBLOCK, 0,            0,    0,  0,      0,  1, ST_OK),
      row(KIND_READ,    0,            0,    0,  0,      1,  0, ST_OK)
   };

   initial begin
      int phase_pct[4] = '{0, 48, 0, 27};
      for (int i = 0; i < SLOTS; i++) slot_mem[i] = '0;
      head_pos = '0;
      tail_pos = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) issue(directed[i]);
      open_offsets.delete();
      for (int i = 0; i < N_RANDOM; i++) begin
         idle_pct = phase_pct[(i * 4) / N_RANDOM];
         issue(random_request());
      end
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
